@@ hdl/rpi_pkg.sv @@
// rpi_pkg: types and constants shared by the ray-plane intersection unit
// no dependencies

package rpi_pkg;

   localparam int VAL_W = 32;
   localparam int SN_W  = 18;
   localparam int IDX_W = 3;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_FN_X   = 3'd0;
   localparam logic [IDX_W-1:0] REG_FN_Y   = 3'd1;
   localparam logic [IDX_W-1:0] REG_FN_Z   = 3'd2;
   localparam logic [IDX_W-1:0] REG_OFFSET = 3'd3;
   localparam logic [IDX_W-1:0] REG_SN_X   = 3'd4;
   localparam logic [IDX_W-1:0] REG_SN_Y   = 3'd5;
   localparam logic [IDX_W-1:0] REG_SN_Z   = 3'd6;

   localparam logic [VAL_W-1:0] ONE_Q16   = 32'h0001_0000;
   localparam logic [SN_W-1:0]  SN_ONE    = 18'h1_0000;
   localparam logic [SN_W-1:0]  SN_MIN    = 18'h2_0000;
   localparam logic [SN_W-1:0]  SN_MAX    = 18'h1_FFFF;
   localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
   localparam logic [VAL_W:0]   Q_LIMIT   = 33'h0_8000_0000;

   typedef struct packed {
      logic [2:0][VAL_W-1:0] o;
      logic [2:0][VAL_W-1:0] d;
      logic [VAL_W-1:0]      tl;
      logic [VAL_W-1:0]      tu;
   } geom_type;

   typedef struct packed {
      geom_type g;
      logic     neg;
      logic     dz;
      logic     relz;
      logic     flip;
      logic     ov;
   } side_type;

endpackage

@@ hdl/ray_plane_intersect_unit.sv @@
// ray_plane_intersect_unit: pipelined ray against folded plane test, hit point and normal
// depends on rpi_pkg
//
//  channel | ports                         | direction
//  --------+-------------------------------+----------
//  req     | req_valid/req_ready + ray     | in
//  rsp     | rsp_valid/rsp_ready + result  | out
//  csr     | csr_valid/csr_ready, index    | in
//
// 39 register stages: products, dot sums, nudge/abs, side test, 32 restoring
// divider stages (one quotient bit each), t select, t*dir products, output.
// one word enters per cycle while the output is not stalled; the divider sets the depth.
// synchronous reset clears valid bits and loads config registers with defaults only.
// each stage holds while the next is full and stalled, bubbles close up.

module ray_plane_intersect_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rpi_pkg::VAL_W-1:0]  req_origin_x,
   input  logic [rpi_pkg::VAL_W-1:0]  req_origin_y,
   input  logic [rpi_pkg::VAL_W-1:0]  req_origin_z,
   input  logic [rpi_pkg::VAL_W-1:0]  req_dir_x,
   input  logic [rpi_pkg::VAL_W-1:0]  req_dir_y,
   input  logic [rpi_pkg::VAL_W-1:0]  req_dir_z,
   input  logic [rpi_pkg::VAL_W-1:0]  req_t_lower,
   input  logic [rpi_pkg::VAL_W-1:0]  req_t_upper,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic [rpi_pkg::VAL_W-1:0]  rsp_t_value,
   output logic [rpi_pkg::VAL_W-1:0]  rsp_point_x,
   output logic [rpi_pkg::VAL_W-1:0]  rsp_point_y,
   output logic [rpi_pkg::VAL_W-1:0]  rsp_point_z,
   output logic [rpi_pkg::SN_W-1:0]   rsp_out_normal_x,
   output logic [rpi_pkg::SN_W-1:0]   rsp_out_normal_y,
   output logic [rpi_pkg::SN_W-1:0]   rsp_out_normal_z,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rpi_pkg::IDX_W-1:0]  csr_index,
   input  logic [rpi_pkg::VAL_W-1:0]  csr_data
);

   localparam int PW    = 64 - FRAC_BITS;        // floored product width
   localparam int DW    = PW + 3;                // dot product / rel width
   localparam int HW    = DW + FRAC_BITS - 32;   // high part of scaled dividend
   localparam int NUDGE = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int NPW   = DW + 16;               // nudge product width
   localparam int NSW   = NPW - FRAC_BITS;       // nudge term width
   localparam int SW    = DW + 17;               // side test sum width
   localparam int QW    = 32;                    // quotient bits
   localparam int S_MUL  = 0;
   localparam int S_SUM  = 1;
   localparam int S_ABS  = 2;
   localparam int S_SIDE = 3;
   localparam int S_DIV0 = 4;
   localparam int S_T    = S_DIV0 + QW;
   localparam int S_TP   = S_T + 1;
   localparam int S_OUT  = S_TP + 1;
   localparam int NS     = S_OUT + 1;
   localparam logic signed [15:0] NUDGE_S = 16'(NUDGE);

   // configuration registers
   logic signed [31:0] fn_ff [3];
   logic signed [31:0] off_ff;
   logic signed [17:0] sn_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fn_ff[0] <= '0;
         fn_ff[1] <= '0;
         fn_ff[2] <= rpi_pkg::ONE_Q16;
         off_ff   <= '0;
         sn_ff[0] <= '0;
         sn_ff[1] <= '0;
         sn_ff[2] <= rpi_pkg::SN_ONE;
      end else if (csr_valid) begin
         unique case (csr_index)
            rpi_pkg::REG_FN_X:   fn_ff[0] <= csr_data;
            rpi_pkg::REG_FN_Y:   fn_ff[1] <= csr_data;
            rpi_pkg::REG_FN_Z:   fn_ff[2] <= csr_data;
            rpi_pkg::REG_OFFSET: off_ff   <= csr_data;
            rpi_pkg::REG_SN_X:   sn_ff[0] <= csr_data[rpi_pkg::SN_W-1:0];
            rpi_pkg::REG_SN_Y:   sn_ff[1] <= csr_data[rpi_pkg::SN_W-1:0];
            rpi_pkg::REG_SN_Z:   sn_ff[2] <= csr_data[rpi_pkg::SN_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and load enables
   logic [NS-1:0] v_ff;
   logic [NS-1:0] ld;

   always_comb begin
      ld[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   assign req_ready = ld[S_MUL];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage: products of folded normal with origin and direction
   rpi_pkg::geom_type  g_in;
   logic signed [63:0] mo [3];
   logic signed [63:0] md [3];
   rpi_pkg::geom_type  g1_ff;
   logic signed [PW-1:0] po_ff [3];
   logic signed [PW-1:0] pd_ff [3];

   always_comb begin
      g_in.o  = {req_origin_z, req_origin_y, req_origin_x};
      g_in.d  = {req_dir_z, req_dir_y, req_dir_x};
      g_in.tl = req_t_lower;
      g_in.tu = req_t_upper;
      for (int i = 0; i < 3; i++) begin
         mo[i] = fn_ff[i] * $signed(g_in.o[i]);
         md[i] = fn_ff[i] * $signed(g_in.d[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[S_MUL]) begin
         g1_ff <= g_in;
         for (int i = 0; i < 3; i++) begin
            po_ff[i] <= mo[i][63:FRAC_BITS];
            pd_ff[i] <= md[i][63:FRAC_BITS];
         end
      end
   end

   // stage: dot sums
   rpi_pkg::geom_type g2_ff;
   logic signed [DW-1:0] rel_ff;
   logic signed [DW-1:0] dnd_ff;

   always_ff @(posedge clock) begin
      if (ld[S_SUM]) begin
         g2_ff  <= g1_ff;
         rel_ff <= DW'(po_ff[0]) + DW'(po_ff[1]) + DW'(po_ff[2]) - DW'(off_ff);
         dnd_ff <= DW'(pd_ff[0]) + DW'(pd_ff[1]) + DW'(pd_ff[2]);
      end
   end

   // stage: nudge product, magnitudes and signs
   logic signed [NPW-1:0] nprod;
   rpi_pkg::geom_type g3_ff;
   logic signed [DW-1:0]  rel3_ff;
   logic signed [NSW-1:0] nud_ff;
   logic [DW-1:0] an_ff;
   logic [DW-1:0] ad_ff;
   logic neg3_ff, dz3_ff, relz3_ff;

   assign nprod = NPW'(NUDGE_S) * NPW'(dnd_ff);

   always_ff @(posedge clock) begin
      if (ld[S_ABS]) begin
         g3_ff    <= g2_ff;
         rel3_ff  <= rel_ff;
         nud_ff   <= nprod[NPW-1:FRAC_BITS];
         an_ff    <= rel_ff[DW-1] ? -rel_ff : rel_ff;
         ad_ff    <= dnd_ff[DW-1] ? -dnd_ff : dnd_ff;
         // quotient of -rel / dnd is negative when rel and dnd share sign
         neg3_ff  <= (rel_ff > 0) != dnd_ff[DW-1];
         dz3_ff   <= (dnd_ff == '0);
         relz3_ff <= (rel_ff == '0);
      end
   end

   // stage: side test, overflow check, divider set-up
   logic signed [SW-1:0] side_sum;
   logic [HW-1:0] hi;
   logic ov_in;
   rpi_pkg::side_type side_ff [QW+1];
   logic [DW-1:0] r_ff  [QW+1];
   logic [DW-1:0] dv_ff [QW+1];
   logic [31:0]   lo_ff [QW+1];
   logic [QW-1:0] q_ff  [QW+1];

   assign side_sum = SW'(rel3_ff) + SW'(nud_ff);
   assign hi       = an_ff[DW-1:32-FRAC_BITS];
   assign ov_in    = DW'(hi) >= ad_ff;

   always_ff @(posedge clock) begin
      if (ld[S_SIDE]) begin
         side_ff[0].g    <= g3_ff;
         side_ff[0].neg  <= neg3_ff;
         side_ff[0].dz   <= dz3_ff;
         side_ff[0].relz <= relz3_ff;
         side_ff[0].flip <= side_sum < 0;
         side_ff[0].ov   <= ov_in;
         r_ff[0]  <= ov_in ? '0 : DW'(hi);
         dv_ff[0] <= ad_ff;
         lo_ff[0] <= {an_ff[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
         q_ff[0]  <= '0;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [DW:0] r_sh;
      logic [DW:0] diff;
      logic        qb;

      assign r_sh = {r_ff[j], lo_ff[j][QW-1-j]};
      assign diff = r_sh - {1'b0, dv_ff[j]};
      assign qb   = !diff[DW];

      always_ff @(posedge clock) begin
         if (ld[S_DIV0+j]) begin
            side_ff[j+1] <= side_ff[j];
            r_ff[j+1]    <= qb ? diff[DW-1:0] : r_sh[DW-1:0];
            dv_ff[j+1]   <= dv_ff[j];
            lo_ff[j+1]   <= lo_ff[j];
            q_ff[j+1]    <= {q_ff[j][QW-2:0], qb};
         end
      end
   end

   // stage: t selection and window test
   rpi_pkg::side_type sq;
   logic [QW:0]        qc;
   logic signed [31:0] t_div;
   logic signed [31:0] t_in;
   logic               hit_in;
   logic               vld_in;
   rpi_pkg::geom_type  g5_ff;
   logic signed [31:0] t_ff;
   logic hit5_ff, vld5_ff, flip5_ff;

   always_comb begin
      sq = side_ff[QW];
      if (sq.ov || ({1'b0, q_ff[QW]} > rpi_pkg::Q_LIMIT)) begin
         qc = rpi_pkg::Q_LIMIT;
      end else begin
         qc = {1'b0, q_ff[QW]};
      end
      if (sq.neg) begin
         t_div = -qc[31:0];
      end else if (qc >= rpi_pkg::Q_LIMIT) begin
         t_div = rpi_pkg::VAL_MAX;
      end else begin
         t_div = qc[31:0];
      end
      vld_in = 1'b1;
      priority if (!sq.dz) begin
         t_in   = t_div;
         hit_in = ($signed(sq.g.tl) <= t_div) && (t_div <= $signed(sq.g.tu));
      end else if (sq.relz) begin
         // ray lies in the plane
         t_in   = ($signed(sq.g.tl) > 0) ? $signed(sq.g.tl) : '0;
         hit_in = 1'b1;
      end else begin
         t_in   = '0;
         hit_in = 1'b0;
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[S_T]) begin
         g5_ff    <= sq.g;
         t_ff     <= t_in;
         hit5_ff  <= hit_in;
         vld5_ff  <= vld_in;
         flip5_ff <= sq.flip;
      end
   end

   // stage: t times direction
   logic signed [63:0] mt [3];
   logic signed [PW-1:0] tp_ff [3];
   logic [2:0][31:0] o6_ff;
   logic signed [31:0] t6_ff;
   logic hit6_ff, vld6_ff, flip6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mt[i] = t_ff * $signed(g5_ff.d[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[S_TP]) begin
         for (int i = 0; i < 3; i++) begin
            tp_ff[i] <= mt[i][63:FRAC_BITS];
         end
         o6_ff    <= g5_ff.o;
         t6_ff    <= t_ff;
         hit6_ff  <= hit5_ff;
         vld6_ff  <= vld5_ff;
         flip6_ff <= flip5_ff;
      end
   end

   // stage: hit point saturation, normal flip, output word
   logic signed [PW:0] ps [3];
   logic [31:0] pt_in [3];
   logic [17:0] nm_in [3];
   logic [31:0] pt_ff [3];
   logic [17:0] nm_ff [3];
   logic        hit_ff;
   logic        vld_ff;
   logic [31:0] tout_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ps[i] = (PW+1)'($signed(o6_ff[i])) + (PW+1)'(tp_ff[i]);
         if (ps[i][PW:31] == {(PW-30){ps[i][PW]}}) begin
            pt_in[i] = ps[i][31:0];
         end else begin
            pt_in[i] = ps[i][PW] ? rpi_pkg::VAL_MIN : rpi_pkg::VAL_MAX;
         end
         if (!flip6_ff) begin
            nm_in[i] = sn_ff[i];
         end else if (sn_ff[i] == rpi_pkg::SN_MIN) begin
            nm_in[i] = rpi_pkg::SN_MAX;
         end else begin
            nm_in[i] = -sn_ff[i];
         end
         if (!vld6_ff) begin
            pt_in[i] = '0;
            nm_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[S_OUT]) begin
         pt_ff   <= pt_in;
         nm_ff   <= nm_in;
         hit_ff  <= hit6_ff;
         vld_ff  <= vld6_ff;
         tout_ff <= t6_ff;
      end
   end

   assign rsp_valid        = v_ff[S_OUT];
   assign rsp_hit          = hit_ff;
   assign rsp_t_value      = tout_ff;
   assign rsp_point_x      = pt_ff[0];
   assign rsp_point_y      = pt_ff[1];
   assign rsp_point_z      = pt_ff[2];
   assign rsp_out_normal_x = nm_ff[0];
   assign rsp_out_normal_y = nm_ff[1];
   assign rsp_out_normal_z = nm_ff[2];

   // a taken output slot frees the whole pipe
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output side is ready");

   a_empty_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   // parallel miss gives an all-zero word
   a_parallel_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !vld_ff) |-> (!rsp_hit && rsp_t_value == '0 && rsp_out_normal_x == '0))
      else $error("parallel miss word not cleared");

endmodule

@@ tb/ray_plane_intersect_unit_tb.sv @@
// ray_plane_intersect_unit_tb: self-checking bench for the ray against plane unit
// depends on rpi_pkg and ray_plane_intersect_unit; predicts each result word and
// compares it in order, with random gaps on both channels and csr writes when idle

module ray_plane_intersect_unit_tb;

   typedef struct packed {
      logic                      hit;
      logic [rpi_pkg::VAL_W-1:0] t;
      logic [rpi_pkg::VAL_W-1:0] px;
      logic [rpi_pkg::VAL_W-1:0] py;
      logic [rpi_pkg::VAL_W-1:0] pz;
      logic [rpi_pkg::SN_W-1:0]  nx;
      logic [rpi_pkg::SN_W-1:0]  ny;
      logic [rpi_pkg::SN_W-1:0]  nz;
   } crossing_type;

   localparam int DRAIN_CYCLES = 45;
   localparam int CYCLE_LIMIT  = 400000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [rpi_pkg::VAL_W-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic [rpi_pkg::VAL_W-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [rpi_pkg::VAL_W-1:0] req_t_lower = '0, req_t_upper = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_hit;
   logic [rpi_pkg::VAL_W-1:0] rsp_t_value, rsp_point_x, rsp_point_y, rsp_point_z;
   logic [rpi_pkg::SN_W-1:0]  rsp_out_normal_x, rsp_out_normal_y, rsp_out_normal_z;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [rpi_pkg::IDX_W-1:0] csr_index = '0;
   logic [rpi_pkg::VAL_W-1:0] csr_data = '0;

   ray_plane_intersect_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the csr registers
   logic [rpi_pkg::VAL_W-1:0] fold_n [3];
   logic [rpi_pkg::VAL_W-1:0] plane_off;
   logic [rpi_pkg::SN_W-1:0]  surf_n [3];

   crossing_type crossings_due [$];
   int  failures = 0;
   int  cycles = 0;
   int  send_gap_max = 12;
   int  stall_max = 12;
   int  stall_left = 0;

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic crossing_type trace_plane(rpi_pkg::geom_type g);
      crossing_type      c;
      longint            o [3], d [3], pt [3], nrm [3];
      longint            tl, tu, dno, dnd, rel, t, n;
      longint unsigned   an, ad, q, rm;
      bit                neg, flip, hit, on_plane;
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'($signed(g.o[i]));
         d[i] = longint'($signed(g.d[i]));
      end
      tl = longint'($signed(g.tl));
      tu = longint'($signed(g.tu));
      dno = 0;
      dnd = 0;
      for (int i = 0; i < 3; i++) begin
         dno += qmul(longint'($signed(fold_n[i])), o[i]);
         dnd += qmul(longint'($signed(fold_n[i])), d[i]);
      end
      rel = dno - longint'($signed(plane_off));
      flip = (rel + ((66 * dnd) >>> 16)) < 0;
      hit = 1'b0;
      on_plane = 1'b1;
      t = 0;
      if (dnd != 0) begin
         n = -rel;
         neg = (n < 0) != (dnd < 0);
         an = n < 0 ? -n : n;
         ad = dnd < 0 ? -dnd : dnd;
         q = an / ad;
         rm = an % ad;
         if (q > 64'd32768) begin
            q = 64'd2147483648;
         end else begin
            for (int i = 0; i < 16; i++) begin
               rm = rm << 1;
               q = q << 1;
               if (rm >= ad) begin
                  rm -= ad;
                  q |= 1;
               end
            end
            if (q > 64'd2147483648) q = 64'd2147483648;
         end
         if (neg) t = -longint'(q);
         else t = (q >= 64'd2147483648) ? 64'sd2147483647 : longint'(q);
         hit = (tl <= t) && (t <= tu);
      end else if (rel == 0) begin
         t = tl > 0 ? tl : 0;
         hit = 1'b1;
      end else begin
         on_plane = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         pt[i] = 0;
         nrm[i] = 0;
         if (on_plane) begin
            pt[i] = sat32(o[i] + qmul(t, d[i]));
            nrm[i] = longint'($signed(surf_n[i]));
            if (flip) nrm[i] = (nrm[i] == -131072) ? 131071 : -nrm[i];
         end
      end
      c.hit = hit;
      c.t = t[31:0];
      c.px = pt[0][31:0];
      c.py = pt[1][31:0];
      c.pz = pt[2][31:0];
      c.nx = nrm[0][rpi_pkg::SN_W-1:0];
      c.ny = nrm[1][rpi_pkg::SN_W-1:0];
      c.nz = nrm[2][rpi_pkg::SN_W-1:0];
      return c;
   endfunction

   task automatic compare_field(string name, logic [rpi_pkg::VAL_W-1:0] want,
                                logic [rpi_pkg::VAL_W-1:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // result side: check each word and draw the next stall
   always @(posedge clock) begin
      crossing_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (crossings_due.size() == 0) begin
            failures++;
            $display("%0t unexpected result word: expected none, actual t %h", $time,
                     rsp_t_value);
         end else begin
            want = crossings_due.pop_front();
            compare_field("hit", rpi_pkg::VAL_W'(want.hit), rpi_pkg::VAL_W'(rsp_hit));
            compare_field("t_value", want.t, rsp_t_value);
            compare_field("point_x", want.px, rsp_point_x);
            compare_field("point_y", want.py, rsp_point_y);
            compare_field("point_z", want.pz, rsp_point_z);
            compare_field("normal_x", rpi_pkg::VAL_W'(want.nx),
                          rpi_pkg::VAL_W'(rsp_out_normal_x));
            compare_field("normal_y", rpi_pkg::VAL_W'(want.ny),
                          rpi_pkg::VAL_W'(rsp_out_normal_y));
            compare_field("normal_z", rpi_pkg::VAL_W'(want.nz),
                          rpi_pkg::VAL_W'(rsp_out_normal_z));
         end
         stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_ray(rpi_pkg::geom_type g);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= g.o[0];
      req_origin_y <= g.o[1];
      req_origin_z <= g.o[2];
      req_dir_x <= g.d[0];
      req_dir_y <= g.d[1];
      req_dir_z <= g.d[2];
      req_t_lower <= g.tl;
      req_t_upper <= g.tu;
      do @(posedge clock); while (!req_ready);
      crossings_due.push_back(trace_plane(g));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (crossings_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so that writes can follow back to back
   task automatic write_reg(logic [rpi_pkg::IDX_W-1:0] idx, logic [rpi_pkg::VAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rpi_pkg::REG_FN_X: fold_n[0] = value;
         rpi_pkg::REG_FN_Y: fold_n[1] = value;
         rpi_pkg::REG_FN_Z: fold_n[2] = value;
         rpi_pkg::REG_OFFSET: plane_off = value;
         rpi_pkg::REG_SN_X: surf_n[0] = value[rpi_pkg::SN_W-1:0];
         rpi_pkg::REG_SN_Y: surf_n[1] = value[rpi_pkg::SN_W-1:0];
         rpi_pkg::REG_SN_Z: surf_n[2] = value[rpi_pkg::SN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_plane(logic [rpi_pkg::VAL_W-1:0] nx, logic [rpi_pkg::VAL_W-1:0] ny,
                             logic [rpi_pkg::VAL_W-1:0] nz, logic [rpi_pkg::VAL_W-1:0] off,
                             logic [rpi_pkg::SN_W-1:0] sx, logic [rpi_pkg::SN_W-1:0] sy,
                             logic [rpi_pkg::SN_W-1:0] sz);
      wait_idle();
      write_reg(rpi_pkg::REG_FN_X, nx);
      write_reg(rpi_pkg::REG_FN_Y, ny);
      write_reg(rpi_pkg::REG_FN_Z, nz);
      write_reg(rpi_pkg::REG_OFFSET, off);
      write_reg(rpi_pkg::REG_SN_X, {{(rpi_pkg::VAL_W-rpi_pkg::SN_W){sx[rpi_pkg::SN_W-1]}}, sx});
      write_reg(rpi_pkg::REG_SN_Y, {{(rpi_pkg::VAL_W-rpi_pkg::SN_W){sy[rpi_pkg::SN_W-1]}}, sy});
      write_reg(rpi_pkg::REG_SN_Z, {{(rpi_pkg::VAL_W-rpi_pkg::SN_W){sz[rpi_pkg::SN_W-1]}}, sz});
      csr_valid <= 1'b0;
   endtask

   function automatic rpi_pkg::geom_type make_ray(
         logic [rpi_pkg::VAL_W-1:0] ox, logic [rpi_pkg::VAL_W-1:0] oy,
         logic [rpi_pkg::VAL_W-1:0] oz, logic [rpi_pkg::VAL_W-1:0] dx,
         logic [rpi_pkg::VAL_W-1:0] dy, logic [rpi_pkg::VAL_W-1:0] dz,
         logic [rpi_pkg::VAL_W-1:0] tl, logic [rpi_pkg::VAL_W-1:0] tu);
      rpi_pkg::geom_type g;
      g.o[0] = ox; g.o[1] = oy; g.o[2] = oz;
      g.d[0] = dx; g.d[1] = dy; g.d[2] = dz;
      g.tl = tl; g.tu = tu;
      return g;
   endfunction

   function automatic logic [rpi_pkg::VAL_W-1:0] near_value();
      // within about +-8.0 so that products stay in range
      return $unsigned(int'($urandom_range(0, 1 << 20)) - (1 << 19));
   endfunction

   function automatic rpi_pkg::geom_type random_ray();
      rpi_pkg::geom_type g;
      int       kind, axis;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         g.o[i] = (kind < 6) ? near_value() : $urandom;
         g.d[i] = (kind < 6) ? near_value() : $urandom;
      end
      g.tl = $unsigned(-int'($urandom_range(0, 1 << 18)));
      g.tu = $urandom_range(0, 1 << 22);
      if (kind == 6) begin
         g.tl = $urandom;
         g.tu = $urandom;
      end else if (kind == 7) begin
         // empty window
         g.tl = $urandom_range(1 << 16, 1 << 20);
         g.tu = g.tl - $urandom_range(1, 1 << 16);
      end
      if (kind >= 8) begin
         // parallel: clear every direction component the folded normal sees
         for (int i = 0; i < 3; i++) if (fold_n[i] != '0) g.d[i] = '0;
         axis = -1;
         for (int i = 0; i < 3; i++) if (fold_n[i] == rpi_pkg::ONE_Q16) axis = i;
         if (kind == 9 && axis >= 0) g.o[axis] = plane_off;
      end
      return g;
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            // each stretch, each side runs flat out with a one in four chance
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
         end
         send_ray(random_ray());
      end
   endtask

   task automatic test_reset_plane();
      logic [rpi_pkg::VAL_W-1:0] neg1;
      logic [rpi_pkg::VAL_W-1:0] one;
      logic [rpi_pkg::VAL_W-1:0] vmax;
      logic [rpi_pkg::VAL_W-1:0] vmin;
      one = rpi_pkg::ONE_Q16;
      vmax = rpi_pkg::VAL_MAX;
      vmin = rpi_pkg::VAL_MIN;
      neg1 = -one;
      // plane z = 0, normal +z
      send_ray(make_ray(0, 0, 5 * one, 0, 0, neg1, 0, 10 * one));
      send_ray(make_ray(one, neg1, 5 * one, one, 0, neg1, 0, 2 * one));
      send_ray(make_ray(0, 0, neg1, 0, 0, one, 0, 4 * one));
      // in plane, window below and above zero
      send_ray(make_ray(0, 0, 0, one, 0, 0, -5 * one, one));
      send_ray(make_ray(0, 0, 0, 0, one, 0, 3 * one, 0));
      // parallel off the plane
      send_ray(make_ray(0, 0, one, one, one, 0, 0, vmax));
      // empty window
      send_ray(make_ray(0, 0, 2 * one, 0, 0, neg1, 5 * one, one));
      // zero direction
      send_ray(make_ray(5, 6, 7, 0, 0, 0, vmin, vmax));
      // field extremes, t saturation both ways
      send_ray(make_ray(vmax, vmin, vmax, vmin, vmax, 1, vmin, vmax));
      send_ray(make_ray(vmin, vmax, vmin, vmax, vmin, neg1, vmin, vmax));
      send_ray(make_ray(0, 0, vmax, vmax, vmax, vmin, vmin, vmax));
      send_ray(make_ray('1, '1, '1, '1, '1, '1, '1, '1));
      send_ray(make_ray(0, 0, 0, 0, 0, one, vmax, vmin));
      // nudge decides the side
      send_ray(make_ray(0, 0, $unsigned(-32'sd30), 0, 0, one, vmin, vmax));
      send_ray(make_ray(0, 0, $unsigned(-32'sd70), 0, 0, one, vmin, vmax));
   endtask

   task automatic test_normal_saturation();
      logic [rpi_pkg::VAL_W-1:0] neg1;
      logic [rpi_pkg::VAL_W-1:0] one;
      one = rpi_pkg::ONE_Q16;
      neg1 = -one;
      load_plane(0, 0, one, 0, rpi_pkg::SN_MIN, rpi_pkg::SN_MAX, rpi_pkg::SN_ONE);
      send_ray(make_ray(0, 0, neg1, 0, 0, one, 0, rpi_pkg::VAL_MAX));
      send_ray(make_ray(0, 0, one, 0, 0, neg1, 0, rpi_pkg::VAL_MAX));
      run_random(100);
   endtask

   task automatic test_plane_sweep();
      logic [rpi_pkg::VAL_W-1:0] n [3];
      load_plane(0, 0, rpi_pkg::ONE_Q16, 2 * rpi_pkg::ONE_Q16, 0, 0, rpi_pkg::SN_ONE);
      run_random(200);
      load_plane(rpi_pkg::ONE_Q16, 0, 0, $unsigned(-32'sd196608), rpi_pkg::SN_ONE, 0, 0);
      run_random(200);
      load_plane(rpi_pkg::VAL_MAX, rpi_pkg::VAL_MAX, rpi_pkg::VAL_MAX, rpi_pkg::VAL_MIN,
                 rpi_pkg::SN_MAX, rpi_pkg::SN_MAX, rpi_pkg::SN_MAX);
      run_random(150);
      load_plane(rpi_pkg::VAL_MIN, rpi_pkg::VAL_MIN, rpi_pkg::VAL_MIN, rpi_pkg::VAL_MAX,
                 rpi_pkg::SN_MIN, rpi_pkg::SN_MIN, rpi_pkg::SN_MIN);
      run_random(150);
      for (int i = 0; i < 3; i++) n[i] = $unsigned(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      load_plane(n[0], n[1], n[2], near_value(), rpi_pkg::SN_W'($urandom),
                 rpi_pkg::SN_W'($urandom), rpi_pkg::SN_W'($urandom));
      run_random(250);
      load_plane($urandom, $urandom, $urandom, $urandom, rpi_pkg::SN_W'($urandom),
                 rpi_pkg::SN_W'($urandom), rpi_pkg::SN_W'($urandom));
      run_random(250);
   endtask

   initial begin
      fold_n[0] = '0; fold_n[1] = '0; fold_n[2] = rpi_pkg::ONE_Q16;
      plane_off = '0;
      surf_n[0] = '0; surf_n[1] = '0; surf_n[2] = rpi_pkg::SN_ONE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_plane();
      test_normal_saturation();
      test_plane_sweep();
      wait_idle();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
